/* src/swmt_pkg.sv */
`default_nettype none
package swmt_pkg;

  localparam int DATA_W = 16;
  localparam int WINDOW_LEN_DEF = 8;
  localparam logic [DATA_W-1:0] SPREAD_LIMIT_RST = 16'd16;
  localparam logic [DATA_W-1:0] RANGE_LO_INIT = '1;
  localparam logic [DATA_W-1:0] RANGE_HI_INIT = '0;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
  } range_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* src/swmt_cell.sv */
`default_nettype none
module swmt_cell import swmt_pkg::*; #(
  parameter int SUM_W = DATA_W + 3
) (
  input  wire logic              clk,
  input  wire logic              shift_en,
  input  wire logic [DATA_W-1:0] smp_i,
  output logic      [DATA_W-1:0] smp_o,
  input  wire logic [SUM_W-1:0]  sum_i,
  input  wire range_t            rng_i,
  output logic      [SUM_W-1:0]  sum_o,
  output range_t                 rng_o
);

  logic [DATA_W-1:0] val_r;
  logic [SUM_W-1:0]  sum_r;
  range_t            rng_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= smp_i;
    end
  end

  // partial sum / min / max moves one cell per cycle
  always_ff @(posedge clk) begin
    sum_r    <= sum_i + SUM_W'(val_r);
    rng_r.lo <= (val_r < rng_i.lo) ? val_r : rng_i.lo;
    rng_r.hi <= (val_r > rng_i.hi) ? val_r : rng_i.hi;
  end

  assign smp_o = val_r;
  assign sum_o = sum_r;
  assign rng_o = rng_r;

endmodule
`default_nettype wire

/* src/swmt_div.sv */
`default_nettype none
module swmt_div import swmt_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       start,
  input  wire logic [DATA_W+$clog2(WINDOW_LEN)-1:0]       sum_i,
  output logic      [DATA_W-1:0]                          quot
);

  localparam int LW      = $clog2(WINDOW_LEN);
  localparam int SUM_W   = DATA_W + LW;
  localparam int SHIFT   = SUM_W + LW;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SHIFT + DATA_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] quo_r;

  // sum / WINDOW_LEN as a multiply by the rounded-up reciprocal, exact over the sum range
  assign prod = PROD_W'(sum_i) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= prod[SHIFT +: DATA_W];
    end
  end

  assign quot = quo_r;

endmodule
`default_nettype wire

/* src/stable_window_minimum_target.sv */
// While the window fills, an accepted item goes from ST_IDLE straight to ST_DONE; once it
// is full, it passes ST_SCAN (partial-sum chain pass) and ST_DIV (reciprocal-multiply mean).
// ST_DONE loads the result once the output register is free; only ST_IDLE takes an item.
// A waiting result sits in the output register while the next item is taken.
// Reset (rst_n low, synchronous): window empty, target 0, spread_limit 16.
`default_nettype none
module stable_window_minimum_target import swmt_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [DATA_W-1:0] cfg_wdata,   // spread_limit
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,    // [15:0] sample
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [31:0]       out_tdata,   // [15:0] target, [31:16] window_mean
  output logic      [1:0]        out_tuser    // [0] window_full, [1] steady
);

  localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SCAN_W = $clog2(WINDOW_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW_LEN);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(WINDOW_LEN);

  state_t            state_r, state_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [SCAN_W-1:0] scan_cnt_r;
  logic              eval_r;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic [DATA_W-1:0] limit_r;
  logic              out_tvalid_r;
  logic [31:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  logic              accept, eval_now, scan_last, out_free, out_load, div_start;
  logic [DATA_W-1:0] mean, spread, res_mean;
  logic              steady, res_steady;

  logic [DATA_W-1:0] smp_q [WINDOW_LEN];
  logic [SUM_W-1:0]  sum_q [WINDOW_LEN+1];
  range_t            rng_q [WINDOW_LEN+1];

  assign sum_q[0]    = '0;
  assign rng_q[0].lo = RANGE_LO_INIT;
  assign rng_q[0].hi = RANGE_HI_INIT;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    swmt_cell #(.SUM_W(SUM_W)) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .smp_i    ((i == 0) ? in_tdata[DATA_W-1:0] : smp_q[(i == 0) ? 0 : i-1]),
      .smp_o    (smp_q[i]),
      .sum_i    (sum_q[i]),
      .rng_i    (rng_q[i]),
      .sum_o    (sum_q[i+1]),
      .rng_o    (rng_q[i+1])
    );
  end

  swmt_div #(.WINDOW_LEN(WINDOW_LEN)) u_div (
    .clk   (clk),
    .start (div_start),
    .sum_i (sum_q[WINDOW_LEN]),
    .quot  (mean)
  );

  assign accept    = in_tvalid && in_tready;
  assign eval_now  = fill_r >= FILL_LAST;
  assign scan_last = scan_cnt_r == SCAN_LAST;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = eval_now ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SCAN: div_start = scan_last;
      ST_DIV:  ;
      ST_DONE: out_load  = out_free;
      default: ;
    endcase
  end

  assign spread     = rng_q[WINDOW_LEN].hi - rng_q[WINDOW_LEN].lo;
  assign steady     = spread <= limit_r;
  assign res_mean   = eval_r ? mean : '0;
  assign res_steady = eval_r && steady;

  always_comb begin
    held_nxt = held_r;
    if (eval_r) begin
      if (held_r == '0) begin
        held_nxt = mean;
      end else if (held_r > mean && steady) begin
        held_nxt = mean;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      scan_cnt_r   <= '0;
      eval_r       <= 1'b0;
      held_r       <= '0;
      limit_r      <= SPREAD_LIMIT_RST;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        eval_r     <= eval_now;
        scan_cnt_r <= '0;
        if (fill_r != FILL_MAX) begin
          fill_r <= fill_r + 1'b1;
        end
      end else if (state_r == ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      if (out_load) begin
        held_r       <= held_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {res_mean, held_nxt};
      out_tuser_r <= {res_steady, eval_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

/* src/swmt_chk.sv */
`default_nettype none
module swmt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item in flight");

  a_unfilled_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[31:16] == 16'd0 && !out_tuser[1])
    else $error("mean or steady set before window full");

  a_unset_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tdata[15:0] == 16'd0 |-> out_tdata[31:16] == 16'd0)
    else $error("target left unset with nonzero mean");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind stable_window_minimum_target swmt_chk u_swmt_chk (.*);
`default_nettype wire

/* tb/stable_window_minimum_target_test.sv */
`timescale 1ns / 100ps
module stable_window_minimum_target_test;
  import swmt_pkg::*;

  localparam int WIN_LEN     = WINDOW_LEN_DEF;
  localparam int DIR_ROWS    = 25;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 112;

  typedef struct packed {
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] mean;
    logic              full;
    logic              steady;
  } reading_t;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              known;
    reading_t          res;
  } dir_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [DATA_W-1:0] cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic [15:0]       in_tdata   = '0;
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [31:0]       out_tdata;
  logic [1:0]        out_tuser;

  stable_window_minimum_target #(
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // window predictor state
  logic [DATA_W-1:0] win_q [WIN_LEN];
  int unsigned       wr_slot    = 0;
  int unsigned       filled     = 0;
  logic [DATA_W-1:0] held_tgt   = '0;
  logic [DATA_W-1:0] spread_lim = SPREAD_LIMIT_RST;

  reading_t readings_due [$];
  dir_row_t dir_rows [DIR_ROWS];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int steady_seen   = 0;
  int n_settings    = 0;

  function automatic reading_t next_reading(input logic [DATA_W-1:0] s);
    reading_t          r;
    int unsigned       sum;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    r = '0;
    win_q[wr_slot] = s;
    wr_slot = (wr_slot + 1) % WIN_LEN;
    if (filled < WIN_LEN) filled++;
    if (filled == WIN_LEN) begin
      sum = 0;
      lo  = win_q[0];
      hi  = win_q[0];
      foreach (win_q[i]) begin
        sum += win_q[i];
        if (win_q[i] < lo) lo = win_q[i];
        if (win_q[i] > hi) hi = win_q[i];
      end
      r.mean   = DATA_W'(sum / WIN_LEN);
      r.full   = 1'b1;
      r.steady = ((hi - lo) <= spread_lim);
      if (held_tgt == '0) held_tgt = r.mean;
      if (held_tgt > r.mean && r.steady) held_tgt = r.mean;
    end
    r.target = held_tgt;
    return r;
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tuser[0], out_tuser[1]};
      results_seen++;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual target=%0d mean=%0d full=%0d steady=%0d",
                 $time, got.target, got.mean, got.full, got.steady);
        errors++;
      end else begin
        want = readings_due.pop_front();
        check_field("target", want.target, got.target);
        check_field("window_mean", want.mean, got.mean);
        check_field("window_full", want.full, got.full);
        check_field("steady", want.steady, got.steady);
        if (got.steady) steady_seen++;
      end
    end
  end

  task automatic send_reading(input logic [DATA_W-1:0] s, input logic known,
                              input reading_t known_res);
    reading_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    r = next_reading(s);
    readings_due.push_back(known ? known_res : r);
    items_sent++;
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (WIN_LEN + 20) @(posedge clk);
  endtask

  task automatic write_spread_limit(input logic [DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    spread_lim = v;
    n_settings++;
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] limits [N_PHASES];
    int                v;
    int                level;
    int                jit;
    int                jit_max;
    int                run_left;
    // sample, known, target, mean, full, steady
    dir_rows[0]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[1]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[2]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[3]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[4]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[5]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[6]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b0, 1'b0};
    dir_rows[7]  = {16'd0,     1'b1, 16'd0,    16'd0,     1'b1, 1'b1}; // zero mean, stays unset
    dir_rows[8]  = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[9]  = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[10] = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[11] = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[12] = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[13] = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[14] = {16'hFFFF,  1'b0, 34'd0};
    dir_rows[15] = {16'hFFFF,  1'b1, 16'd8191, 16'hFFFF,  1'b1, 1'b1};
    dir_rows[16] = {16'd100,   1'b0, 34'd0};
    dir_rows[17] = {16'd100,   1'b0, 34'd0};
    dir_rows[18] = {16'd100,   1'b0, 34'd0};
    dir_rows[19] = {16'd100,   1'b0, 34'd0};
    dir_rows[20] = {16'd100,   1'b0, 34'd0};
    dir_rows[21] = {16'd100,   1'b0, 34'd0};
    dir_rows[22] = {16'd100,   1'b0, 34'd0};
    dir_rows[23] = {16'd100,   1'b1, 16'd100,  16'd100,   1'b1, 1'b1}; // steady, lowered
    dir_rows[24] = {16'd100,   1'b1, 16'd100,  16'd100,   1'b1, 1'b1}; // mean equals target

    limits[0] = '0;
    limits[1] = 16'hFFFF;
    limits[2] = DATA_W'($urandom_range(1, 64));
    limits[3] = DATA_W'($urandom_range(0, 65535));
    limits[4] = 16'hFFFF;
    limits[5] = '0;
    limits[6] = DATA_W'($urandom_range(16, 400));
    limits[7] = SPREAD_LIMIT_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_reading(dir_rows[i].sample, dir_rows[i].known, dir_rows[i].res);
    drain_and_settle();

    run_left = 0;
    level    = 0;
    jit      = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_spread_limit(limits[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // runs of readings around one level, mostly within the spread limit
        if (run_left == 0) begin
          run_left = $urandom_range(6, 24);
          case ($urandom_range(0, 7))
            0:       level = 0;
            1, 2:    level = $urandom_range(0, 255);
            default: level = $urandom_range(0, 65535);
          endcase
          jit_max = (spread_lim > 300) ? 300 : int'(spread_lim);
          jit = ($urandom_range(0, 4) == 0) ? 4 * jit_max + 8 : $urandom_range(0, jit_max);
        end
        run_left--;
        if ($urandom_range(0, 99) < 4) begin
          v = $urandom_range(0, 65535);
        end else begin
          v = level + $urandom_range(0, jit);
          if (v > 65535) v = 65535;
        end
        send_reading(DATA_W'(v), 1'b0, '0);
      end
      drain_and_settle();
    end

    $display("%0d readings sent over %0d spread_limit settings, %0d results checked",
             items_sent, n_settings, results_seen);
    $display("%0d steady windows seen, with sender gaps and receiver stalls in turn",
             steady_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
